// ----- rtl/core/ssq_pkg.sv -----
// Shared types, sizes and codes for the stable sorted priority queue core.
package ssq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 4;
  localparam int PAY_W = 2;
  localparam int COUNT_OUT_W = 5;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Per-beat command broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

  typedef struct packed {
    logic [KEY_W-1:0]       head_key;
    logic [PAY_W-1:0]       head_payload;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
    logic                   insert_dropped;
  } result_t;

endpackage

// ----- rtl/core/stable_sorted_priority_queue_core.sv -----
// Top level of the stable sorted priority queue core.
// The queue holds up to DEPTH entries in descending key order in a chain of cells, one
// entry per cell, with cell 0 at the head. Each input beat carries an insert or a remove
// command; the whole chain updates in the cycle the beat is accepted, because every cell
// compares its own key with the broadcast new key and then keeps its entry, loads the new
// one, or takes its neighbor's. A new beat can therefore be taken every clock cycle
// while s_tready is high; each result is registered. Entries with equal keys leave in the
// order they arrived. A remove on an empty queue changes nothing; an insert on a full
// queue is discarded and reported through insert_dropped. Every command yields exactly
// one result beat with the head entry, the entry count and the flags as they stand after
// the command. Results sit in a result register backed by a skid register, so the input
// keeps accepting while one result waits; input stalls only once both are full. There is
// no clearing pass after reset: cells outside the stored count are never reported.
module stable_sorted_priority_queue_core
  import ssq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [3:0] key_level, [5:4] payload_kind, [7:6] zero
  input  logic        s_tuser,  // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [3:0] head_key, [5:4] head_payload, [10:6] entry_count,
                                // [11] is_empty, [12] insert_dropped, [15:13] zero
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             dropped;
  cell_ctrl_t       ctrl;
  result_t          res;
  result_t          out_res;

  entry_t           cell_q [DEPTH];
  entry_t           cell_d [DEPTH];
  logic [DEPTH-1:0] cell_ge;

  assign accept = s_tvalid && s_tready;
  assign full   = (count == CNT_W'(DEPTH));

  always_comb begin
    ctrl.new_entry.key     = s_tdata[3:0];
    ctrl.new_entry.payload = s_tdata[5:4];
    ctrl.ins   = accept && (s_tuser == FUNC_INSERT) && !full;
    ctrl.rem   = accept && (s_tuser == FUNC_REMOVE) && (count != '0);
    dropped    = (s_tuser == FUNC_INSERT) && full;
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The chain. Cell 0 always sees a "greater or equal" neighbor on its left, so an insert
  // that beats the head key lands there. The last cell shifts in its own entry on remove.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_mid
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_q[i];
    end else begin : g_body
      assign right_entry = cell_q[i+1];
    end

    ssq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (count > CNT_W'(i)),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (cell_ge[i]),
      .q           (cell_q[i]),
      .d           (cell_d[i])
    );
  end

  // The result reflects the state after the command: the head cell's next entry.
  always_comb begin
    res.is_empty       = (count_next == '0);
    res.head_key       = res.is_empty ? '0 : cell_d[0].key;
    res.head_payload   = res.is_empty ? '0 : cell_d[0].payload;
    res.entry_count    = COUNT_OUT_W'(count_next);
    res.insert_dropped = dropped;
  end

  ssq_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (res),
    .push_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tdata = {3'b000, out_res.insert_dropped, out_res.is_empty, out_res.entry_count,
                    out_res.head_payload, out_res.head_key};

  // The stored count never passes the capacity of the chain.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stored count above capacity");

  // An insert on a full queue leaves the count unchanged.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == FUNC_INSERT) && full |=> count == CNT_W'(DEPTH))
    else $error("insert on full queue changed the count");

  // A remove on a non-empty queue takes exactly one entry away.
  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == FUNC_REMOVE) && (count != '0) |=>
    count == $past(count) - CNT_W'(1))
    else $error("remove did not drop one entry");

  // The input stalls only while results are waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

endmodule

// ----- rtl/core/ssq_cell.sv -----
// One slot of the sorted chain: keeps, loads the new entry, or shifts from a neighbor.
module ssq_cell
  import ssq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       left_ge,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output logic       ge,
  output entry_t     q,
  output entry_t     d
);

  // An occupied slot whose key is at least the new key stays in place on insert.
  assign ge = occ && (q.key >= ctrl.new_entry.key);

  always_comb begin
    d = q;
    if (ctrl.ins) begin
      if (ge) begin
        d = q;
      end else if (left_ge) begin
        d = ctrl.new_entry;
      end else begin
        d = left_entry;
      end
    end else if (ctrl.rem) begin
      d = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

// ----- rtl/core/ssq_out_buf.sv -----
// Two-entry output buffer: a result register plus a skid register.
module ssq_out_buf
  import ssq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_v;
  logic    skid_v;
  result_t skid_data;

  assign push_ready = !skid_v;
  assign out_valid  = main_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (main_v && !out_ready) begin
        skid_v <= 1'b1;
      end else begin
        main_v <= 1'b1;
      end
    end else if (out_ready) begin
      main_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (main_v && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// ----- tb/tb_stable_sorted_priority_queue_core.sv -----
// Self-checking testbench for the stable sorted priority queue core.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the queue, predicts the result beat of each accepted
// command and checks the result beats in order against those predictions.
class queue_scoreboard;
  ssq_pkg::entry_t  slots [ssq_pkg::DEPTH];
  int unsigned      fill;
  ssq_pkg::result_t expected_q [$];
  int unsigned      errors;
  int unsigned      n_insert;
  int unsigned      n_remove;
  int unsigned      n_dropped;
  int unsigned      n_empty_remove;
  int unsigned      n_checked;
  int unsigned      max_fill;

  function new();
    fill = 0;
    errors = 0;
    n_insert = 0;
    n_remove = 0;
    n_dropped = 0;
    n_empty_remove = 0;
    n_checked = 0;
    max_fill = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Applies one accepted command to the model queue and queues the result it must produce.
  function void note_input(logic func, logic [3:0] key, logic [1:0] payload);
    ssq_pkg::result_t want;
    int unsigned      pos;
    want = '0;
    if (func == ssq_pkg::FUNC_INSERT) begin
      n_insert++;
      if (fill >= ssq_pkg::DEPTH) begin
        want.insert_dropped = 1'b1;
        n_dropped++;
      end else begin
        // The new entry goes behind every entry with an equal or larger key.
        pos = 0;
        while (pos < fill && slots[pos].key >= key) pos++;
        for (int unsigned i = fill; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].key = key;
        slots[pos].payload = payload;
        fill++;
      end
    end else begin
      n_remove++;
      if (fill == 0) begin
        n_empty_remove++;
      end else begin
        for (int unsigned i = 1; i < fill; i++) slots[i-1] = slots[i];
        fill--;
      end
    end
    if (fill > max_fill) max_fill = fill;
    if (fill > 0) begin
      want.head_key = slots[0].key;
      want.head_payload = slots[0].payload;
    end
    want.is_empty = (fill == 0);
    want.entry_count = fill[ssq_pkg::COUNT_OUT_W-1:0];
    expected_q.push_back(want);
  endfunction

  function void check_result(logic [15:0] beat);
    ssq_pkg::result_t want;
    ssq_pkg::result_t got;
    bit               ok;
    got.head_key = beat[3:0];
    got.head_payload = beat[5:4];
    got.entry_count = beat[10:6];
    got.is_empty = beat[11];
    got.insert_dropped = beat[12];
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("error: result beat %h arrived with no command outstanding", beat);
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    ok = (got.head_key === want.head_key) && (got.head_payload === want.head_payload) &&
         (got.entry_count === want.entry_count) && (got.is_empty === want.is_empty) &&
         (got.insert_dropped === want.insert_dropped);
    if (!ok) begin
      errors++;
      if (errors <= 10)
        $display("error: result %0d key/pay/count/empty/drop expected %0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%b/%b",
                 n_checked, want.head_key, want.head_payload, want.entry_count, want.is_empty,
                 want.insert_dropped, got.head_key, got.head_payload, got.entry_count,
                 got.is_empty, got.insert_dropped);
    end
  endfunction
endclass

module tb_stable_sorted_priority_queue_core;
  import ssq_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles without any beat before the run is abandoned
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off, well past the two result slots

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // While calm is set neither side inserts idle cycles.
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  queue_scoreboard sb = new();

  always #6 clk = ~clk;

  stable_sorted_priority_queue_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Offers one command beat, with random idle cycles ahead of it, and returns at the edge
  // where it is accepted. tvalid stays high on return so back-to-back beats need no gap.
  task automatic send_command(input logic func, input logic [3:0] key, input logic [1:0] pay);
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, pay, key};
    s_tuser <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(func, key, pay);
  endtask

  // Lowers tvalid and waits until every outstanding result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: checks each accepted result beat and drives tready, including the long
  // hold-off that lets the core fill both result slots and stall its input.
  initial begin : result_sink
    int hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  // Watchdog: any beat on either side restarts the count.
  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("error: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          sent = 0;
    int          group_left = 0;
    int          insert_pct = 50;
    bit          narrow = 1'b0;
    bit          held = 1'b0;
    bit          paused = 1'b0;
    logic        func;
    logic [3:0]  key;
    logic [1:0]  pay;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: remove on an empty queue, extreme keys and payloads, equal keys
    // leaving in arrival order, and draining back to empty.
    send_command(FUNC_REMOVE, 4'd9, 2'd3);
    send_command(FUNC_INSERT, 4'd0, 2'd0);
    send_command(FUNC_REMOVE, 4'd0, 2'd0);
    send_command(FUNC_INSERT, 4'd15, 2'd3);
    send_command(FUNC_INSERT, 4'd15, 2'd1);
    send_command(FUNC_INSERT, 4'd0, 2'd2);
    send_command(FUNC_INSERT, 4'd15, 2'd0);
    send_command(FUNC_INSERT, 4'd8, 2'd1);
    send_command(FUNC_INSERT, 4'd0, 2'd3);
    repeat (6) send_command(FUNC_REMOVE, 4'd15, 2'd3);
    send_command(FUNC_REMOVE, 4'd0, 2'd0);
    send_command(FUNC_INSERT, 4'd5, 2'd3);
    send_command(FUNC_INSERT, 4'd5, 2'd0);
    send_command(FUNC_INSERT, 4'd10, 2'd2);
    send_command(FUNC_INSERT, 4'd5, 2'd1);
    repeat (4) send_command(FUNC_REMOVE, 4'd0, 2'd0);
    wait_drained();

    // Random part: groups of commands with a chosen insert share, so the queue sweeps
    // between empty and full, with some groups on a narrow key range for many ties.
    while (sent < RANDOM_ITEMS) begin
      if (group_left == 0) begin
        group_left = $urandom_range(10, 60);
        case ($urandom_range(4))
          0: insert_pct = 15;
          1: insert_pct = 50;
          2: insert_pct = 80;
          default: insert_pct = 95;
        endcase
        narrow = ($urandom_range(1) == 1);
      end
      group_left--;
      func = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
      key = narrow ? 4'($urandom_range(6, 8)) : 4'($urandom_range(15));
      pay = 2'($urandom_range(3));
      calm = (sent >= 400 && sent < 550);
      if (sent == 300 && !held) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (sent == 650 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      send_command(func, key, pay);
      sent++;
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run: %0d inserts (%0d dropped on a full queue), %0d removes (%0d on empty)",
             sb.n_insert, sb.n_dropped, sb.n_remove, sb.n_empty_remove);
    $display("run: %0d results checked, deepest fill %0d of %0d, %0d errors",
             sb.n_checked, sb.max_fill, DEPTH, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ssq_pkg.sv
rtl/core/ssq_cell.sv
rtl/core/ssq_out_buf.sv
rtl/core/stable_sorted_priority_queue_core.sv
tb/tb_stable_sorted_priority_queue_core.sv
